FILE: design/free_params_to_corr_cholesky_defines.svh
// Assertion macros for the correlation Cholesky block checkers.
`ifndef FREE_PARAMS_TO_CORR_CHOLESKY_DEFINES_SVH
`define FREE_PARAMS_TO_CORR_CHOLESKY_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define CHOLC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define CHOLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/cholc_pkg.sv
// Shared constants, types and helper functions for the correlation Cholesky block.
package cholc_pkg;

  localparam int MAX_DIM     = 8;
  localparam int NUM_FREE    = MAX_DIM * (MAX_DIM - 1) / 2;
  localparam int NUM_TRI     = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int ZA_W        = $clog2(NUM_FREE);
  localparam int XA_W        = $clog2(NUM_TRI);
  localparam int IDX_W       = 3;
  localparam int DIM_W       = 4;
  localparam int CNT_W       = $clog2(NUM_FREE + 1);
  localparam int FREE_W      = 16;
  localparam int ENTRY_W     = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int EXP_STEPS   = 16;
  localparam int DIV_STEPS   = 17;
  localparam int SQRT_STEPS  = 16;

  localparam logic [ENTRY_W-1:0] ONE_Q15 = 17'h08000;

  // one load classified by the front end
  typedef struct packed {
    logic [FREE_W-1:0] value;
    logic [ZA_W-1:0]   idx;
    logic              last;
    logic [IDX_W-1:0]  dm1;
  } q_entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TANH,
    ST_DIV_INIT,
    ST_DIV,
    ST_STORE,
    ST_B_ENTRY,
    ST_B_RD,
    ST_B_SQ,
    ST_B_ACC,
    ST_B_SQI,
    ST_B_SQRT,
    ST_B_ZRD,
    ST_B_ZMUL,
    ST_B_WR,
    ST_E_RD,
    ST_E_LOAD,
    ST_E_HOLD
  } back_state_t;

  typedef logic [31:0] exp_tab_t [EXP_STEPS];

  // exp(-2^k/1024) in Q0.32, each entry the rounded square of the one before
  function automatic exp_tab_t gen_exp_tab();
    longint unsigned f;
    exp_tab_t        t;
    f = 64'd4290775039;
    for (int k = 0; k < EXP_STEPS; k++) begin
      t[k] = f[31:0];
      f = (f * f + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = gen_exp_tab();

  // start of row i in the row-major lower triangle
  function automatic logic [XA_W-1:0] tri_base(input logic [IDX_W-1:0] i);
    logic [7:0] p;
    p = {5'b0, i} * ({5'b0, i} + 8'd1);
    return p[XA_W:1];
  endfunction

  // number of free values for dimension d
  function automatic logic [CNT_W-1:0] num_free(input logic [DIM_W-1:0] d);
    logic [7:0] p;
    p = {4'b0, d} * ({4'b0, d} - 8'd1);
    return p[CNT_W:1];
  endfunction

endpackage

FILE: design/cholc_front.sv
// Front end: dimension register, load counter and classification of each load.
module cholc_front import cholc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [FREE_W-1:0] in_tdata,
  input  logic              cfg_wr_en,
  input  logic [DIM_W-1:0]  cfg_wr_data,
  input  logic              q_full,
  output logic              q_push,
  output q_entry_t          q_data
);

  logic [DIM_W-1:0] dim_r, dim_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIM_W-1:0] d_eff;
  logic [CNT_W-1:0] nfree, idx, idx_inc;
  logic             last;

  always_comb begin
    if (dim_r < DIM_W'(2)) begin
      d_eff = DIM_W'(2);
    end else if (dim_r > DIM_W'(MAX_DIM)) begin
      d_eff = DIM_W'(MAX_DIM);
    end else begin
      d_eff = dim_r;
    end
  end

  assign nfree   = num_free(d_eff);
  assign idx     = (cnt_r >= nfree) ? '0 : cnt_r;
  assign idx_inc = idx + CNT_W'(1);
  assign last    = (idx_inc == nfree);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_data.value = in_tdata;
    q_data.idx   = idx[ZA_W-1:0];
    q_data.last  = last;
    q_data.dm1   = IDX_W'(d_eff - DIM_W'(1));
  end

  always_comb begin
    dim_nxt = cfg_wr_en ? cfg_wr_data : dim_r;
    if (cfg_wr_en) begin
      cnt_nxt = '0;
    end else if (q_push) begin
      cnt_nxt = last ? '0 : idx_inc;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_W'(2);
      cnt_r <= '0;
    end else begin
      dim_r <= dim_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: design/cholc_queue.sv
// Short queue of classified loads between the front end and the back end.
module cholc_queue import cholc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t din,
  input  logic     pop,
  output q_entry_t dout,
  output logic     full,
  output logic     empty
);

  q_entry_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]       cnt_r;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (QPTR_W + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPTR_W + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= din;
  end

endmodule

FILE: design/cholc_back.sv
// Back end: tanh, factor build and emission sequencer with its two stores.
module cholc_back import cholc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  q_entry_t    q_dout,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast
);

  back_state_t state_r, state_nxt;

  q_entry_t            ent_r;
  logic [4:0]          cnt_r;
  logic [FREE_W-1:0]   m_r;
  logic [31:0]         acc_r;
  logic                one_r;
  logic [33:0]         rem_r, den_r;
  logic [16:0]         dlo_r;
  logic [16:0]         q_r;
  logic [IDX_W-1:0]    i_r, j_r, k_r;
  logic [ZA_W-1:0]     zidx_r;
  logic [32:0]         sum_r, sq_r;
  logic [30:0]         a_r;
  logic [31:0]         r_r, bit_r;
  logic signed [33:0]  prod_r;
  logic [XA_W-1:0]     e_addr_r;
  logic [IDX_W-1:0]    er_r, ec_r;
  logic [ENTRY_W-1:0]  out_entry_r;
  logic [IDX_W-1:0]    out_row_r, out_col_r;
  logic                out_last_r;

  logic [ENTRY_W-1:0]  zmem [NUM_FREE];
  logic [ENTRY_W-1:0]  xmem [NUM_TRI];
  logic [ENTRY_W-1:0]  zrd_r, xrd_r;

  logic                z_we, z_re, x_we, x_re;
  logic [ZA_W-1:0]     z_waddr, z_raddr;
  logic [XA_W-1:0]     x_waddr, x_raddr;
  logic [ENTRY_W-1:0]  x_wdata, z_val;

  logic [63:0]         pm, pm_rnd;
  logic [32:0]         e33, num;
  logic [33:0]         den;
  logic [47:0]         dividend;
  logic [34:0]         div_t;
  logic                div_ge;
  logic [31:0]         rb;
  logic                sq_ge;
  logic [15:0]         s_w;
  logic signed [33:0]  sq_w;
  logic                p_neg;
  logic [33:0]         p_mag, p_rm;
  logic [16:0]         p_r17, rounded;
  logic                diag;

  // tanh datapath
  assign pm       = {32'b0, acc_r} * {32'b0, EXP_TAB[cnt_r[3:0]]};
  assign pm_rnd   = pm + 64'h8000_0000;
  assign e33      = one_r ? 33'h1_0000_0000 : {1'b0, acc_r};
  assign num      = 33'h1_0000_0000 - e33;
  assign den      = 34'h1_0000_0000 + {1'b0, e33};
  assign dividend = {num, 15'b0} + {15'b0, den[33:1]};
  assign div_t    = {rem_r, dlo_r[16]};
  assign div_ge   = (div_t >= {1'b0, den_r});
  assign z_val    = ent_r.value[15] ? 17'(~q_r + 17'd1) : q_r;

  // build datapath
  assign sq_w     = $signed(xrd_r) * $signed(xrd_r);
  assign rb       = r_r + bit_r;
  assign sq_ge    = ({1'b0, a_r} >= rb);
  assign s_w      = r_r[15:0];
  assign p_neg    = prod_r[33];
  assign p_mag    = p_neg ? 34'(-prod_r) : 34'(prod_r);
  assign p_rm     = p_mag + 34'h4000;
  assign p_r17    = p_rm[31:15];
  assign rounded  = p_neg ? 17'(~p_r17 + 17'd1) : p_r17;
  assign diag     = (i_r == j_r);

  assign out_tvalid = (state_r == ST_E_HOLD);
  assign out_tdata  = {1'b0, out_entry_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (!q_empty) state_nxt = ST_TANH;
      ST_TANH:     if (cnt_r == 5'(EXP_STEPS - 1)) state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV:      if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = ST_STORE;
      ST_STORE:    state_nxt = ent_r.last ? ST_B_ENTRY : ST_IDLE;
      ST_B_ENTRY:  state_nxt = (j_r == '0) ? ST_B_SQI : ST_B_RD;
      ST_B_RD:     state_nxt = ST_B_SQ;
      ST_B_SQ:     state_nxt = ST_B_ACC;
      ST_B_ACC:    state_nxt = (k_r + IDX_W'(1) == j_r) ? ST_B_SQI : ST_B_RD;
      ST_B_SQI:    state_nxt = ST_B_SQRT;
      ST_B_SQRT: begin
        if (cnt_r == 5'(SQRT_STEPS - 1)) state_nxt = diag ? ST_B_WR : ST_B_ZRD;
      end
      ST_B_ZRD:    state_nxt = ST_B_ZMUL;
      ST_B_ZMUL:   state_nxt = ST_B_WR;
      ST_B_WR: begin
        state_nxt = (i_r == ent_r.dm1 && j_r == ent_r.dm1) ? ST_E_RD : ST_B_ENTRY;
      end
      ST_E_RD:     state_nxt = ST_E_LOAD;
      ST_E_LOAD:   state_nxt = ST_E_HOLD;
      ST_E_HOLD: begin
        if (out_tready) state_nxt = out_last_r ? ST_IDLE : ST_E_RD;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // store and queue controls
  always_comb begin
    q_pop   = 1'b0;
    z_we    = 1'b0;
    z_re    = 1'b0;
    x_we    = 1'b0;
    x_re    = 1'b0;
    z_waddr = ent_r.idx;
    z_raddr = zidx_r;
    x_waddr = XA_W'(tri_base(i_r) + {3'b0, j_r});
    x_raddr = XA_W'(tri_base(i_r) + {3'b0, k_r});
    x_wdata = diag ? {1'b0, s_w} : rounded;
    case (state_r)
      ST_IDLE:  q_pop = !q_empty;
      ST_STORE: z_we  = 1'b1;
      ST_B_RD:  x_re  = 1'b1;
      ST_B_ZRD: z_re  = 1'b1;
      ST_B_WR:  x_we  = 1'b1;
      ST_E_RD: begin
        x_re    = 1'b1;
        x_raddr = e_addr_r;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (z_we) zmem[z_waddr] <= z_val;
    if (z_re) zrd_r <= zmem[z_raddr];
  end

  always_ff @(posedge clk) begin
    if (x_we) xmem[x_waddr] <= x_wdata;
    if (x_re) xrd_r <= xmem[x_raddr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ent_r <= q_dout;
        m_r   <= q_dout.value[15] ? 16'(~q_dout.value + 16'd1) : q_dout.value;
        one_r <= 1'b1;
        cnt_r <= '0;
      end
      ST_TANH: begin
        if (m_r[cnt_r[3:0]]) begin
          one_r <= 1'b0;
          acc_r <= one_r ? EXP_TAB[cnt_r[3:0]] : pm_rnd[63:32];
        end
        cnt_r <= cnt_r + 5'd1;
      end
      ST_DIV_INIT: begin
        rem_r <= {3'b0, dividend[47:17]};
        dlo_r <= dividend[16:0];
        den_r <= den;
        q_r   <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= div_ge ? 34'(div_t - {1'b0, den_r}) : div_t[33:0];
        q_r   <= {q_r[15:0], div_ge};
        dlo_r <= {dlo_r[15:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
      end
      ST_STORE: begin
        i_r    <= '0;
        j_r    <= '0;
        zidx_r <= '0;
      end
      ST_B_ENTRY: begin
        sum_r <= '0;
        k_r   <= '0;
      end
      ST_B_SQ: sq_r <= sq_w[32:0];
      ST_B_ACC: begin
        sum_r <= sum_r + sq_r;
        k_r   <= k_r + IDX_W'(1);
      end
      ST_B_SQI: begin
        // clamp a negative remainder to zero
        a_r   <= (sum_r > 33'h4000_0000) ? '0 : 31'(33'h4000_0000 - sum_r);
        r_r   <= '0;
        bit_r <= 32'h4000_0000;
        cnt_r <= '0;
      end
      ST_B_SQRT: begin
        if (sq_ge) begin
          a_r <= 31'({1'b0, a_r} - rb);
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
      end
      ST_B_ZMUL: prod_r <= $signed(zrd_r) * $signed({1'b0, s_w});
      ST_B_WR: begin
        if (!diag) zidx_r <= zidx_r + ZA_W'(1);
        if (i_r == ent_r.dm1) begin
          j_r <= j_r + IDX_W'(1);
          i_r <= j_r + IDX_W'(1);
        end else begin
          i_r <= i_r + IDX_W'(1);
        end
        e_addr_r <= '0;
        er_r     <= '0;
        ec_r     <= '0;
      end
      ST_E_LOAD: begin
        out_entry_r <= xrd_r;
        out_row_r   <= er_r;
        out_col_r   <= ec_r;
        out_last_r  <= (er_r == ent_r.dm1) && (ec_r == er_r);
      end
      ST_E_HOLD: begin
        if (out_tready) begin
          e_addr_r <= e_addr_r + XA_W'(1);
          if (ec_r == er_r) begin
            er_r <= er_r + IDX_W'(1);
            ec_r <= '0;
          end else begin
            ec_r <= ec_r + IDX_W'(1);
          end
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

endmodule

FILE: design/free_params_to_corr_cholesky.sv
// Top level: free parameters to lower Cholesky factor of a correlation matrix.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------
//  in_     | in  | in_tvalid/in_tready  | free_value (signed Q4.11)
//  out_    | out | out_tvalid/out_tready| row, col, entry (Q1.15), last as tlast
//  cfg_    | in  | cfg_wr_en            | matrix_dim
//
//  Each load passes through the back end in order: capture, the exp product
//  (one 32x32 multiplier), divide setup, the restoring divide and the store.
//  The final load adds the build: per factor entry a read, square and accumulate
//  for each earlier entry in its row, then setup and the bit-pair square root,
//  then a write for a diagonal entry or the z read, multiply and write of an
//  off-diagonal one. Emission reads, loads and holds each entry until out_tready.
//  A two-entry queue lets the front accept loads while the back end is busy.
//  Synchronous active-low reset clears the control state; stores need none.
module free_params_to_corr_cholesky import cholc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [FREE_W-1:0] in_tdata,    // [15:0] free_value
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,   // [2:0] row_index, [5:3] col_index,
                                         // [22:6] entry_value, [23] zero
  output logic              out_tlast,   // last_entry
  input  logic              cfg_wr_en,
  input  logic [DIM_W-1:0]  cfg_wr_data  // matrix_dim
);

  q_entry_t q_din, q_dout;
  logic     q_push, q_pop, q_full, q_empty;

  // front: dimension register and load classification
  cholc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_din)
  );

  // decoupling queue
  cholc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: tanh, factor build, emission
  cholc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: design/cholc_checker.sv
// Port-level checker for the correlation Cholesky block, with its bind.
`include "free_params_to_corr_cholesky_defines.svh"

module cholc_checker import cholc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  `CHOLC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `CHOLC_ASSERT_SAME(a_col_le_row, out_tvalid, out_tdata[5:3] <= out_tdata[2:0], "column above row")
  `CHOLC_ASSERT_SAME(a_last_diag, out_tvalid && out_tlast, (out_tdata[5:3] == out_tdata[2:0]) && (out_tdata[2:0] != 3'd0), "last entry off the diagonal")
  `CHOLC_ASSERT_SAME(a_origin_one, out_tvalid && (out_tdata[5:0] == 6'd0), out_tdata[22:6] == ONE_Q15, "entry (0,0) is not one")

endmodule

bind free_params_to_corr_cholesky cholc_checker u_cholc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
